@@ rtl/cdd_pkg.sv @@
// shared types and constants of the codel drop decider
package cdd_pkg;

  localparam int TIME_W       = 62;
  localparam int STAMP_W      = 63;
  localparam int CMP_W        = 64;
  localparam int IV_MS_W      = 16;
  localparam int BYTES_W      = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int IV_US_W      = 26;
  localparam int IV_NS_W      = 46;
  localparam int TGT_MS_W     = 12;
  localparam int TGT_NS_W     = 42;
  localparam int INV_W        = 8;
  localparam int SQ_W         = 16;
  localparam int BIT_IDX_W    = $clog2(INV_W);
  localparam int SPACING_W    = 36;
  localparam int T_SHIFT      = 8;
  localparam int TARGET_SHIFT = 8;
  localparam int DEC_STEP     = 2;
  localparam int TABLE_LEN    = 227;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'd1;

  localparam logic [IV_MS_W-1:0] INTERVAL_RESET  = 16'd4000;
  localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 16'd512;

  localparam logic [19:0]      NS_PER_MS  = 20'd1000000;
  localparam logic [9:0]       US_PER_MS  = 10'd1000;
  localparam logic [9:0]       NS_PER_US  = 10'd1000;
  localparam logic [3:0]       TARGET_NUM = 4'd13;
  localparam logic [INV_W-1:0] T_ZERO     = 8'd255;
  localparam logic [INV_W-1:0] T_TAIL     = 8'd16;
  localparam logic [16:0]      SQ_LIMIT   = 17'd65536;

  localparam logic [IV_US_W-1:0] IV_US_RESET =
    IV_US_W'(longint'(INTERVAL_RESET) * longint'(US_PER_MS));
  localparam logic [IV_NS_W-1:0] IV_NS_RESET =
    IV_NS_W'(longint'(INTERVAL_RESET) * longint'(NS_PER_MS));
  localparam logic [TGT_MS_W-1:0] TGT_MS_RESET =
    TGT_MS_W'((longint'(INTERVAL_RESET) * longint'(TARGET_NUM)) >> TARGET_SHIFT);
  localparam logic [TGT_NS_W-1:0] TGT_NS_RESET =
    TGT_NS_W'(longint'(TGT_MS_RESET) * longint'(NS_PER_MS));

  typedef struct packed {
    logic                 capture;
    logic                 eval;
    logic                 t_init;
    logic                 srch_step;
    logic [BIT_IDX_W-1:0] srch_bit;
    logic                 mul1;
    logic                 mul2;
    logic                 add;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    logic to_spacing;
    logic need_search;
    logic out_free;
  } status_t;

endpackage

@@ rtl/cdd_if.sv @@
// item channels of the codel drop decider
interface cdd_in_if;
  logic                         valid;
  logic                         ready;
  logic [cdd_pkg::TIME_W-1:0]   now_time;
  logic                         has_enqueue_time;
  logic [cdd_pkg::TIME_W-1:0]   enqueue_time;
  logic                         size_known;
  logic [cdd_pkg::BYTES_W-1:0]  packet_bytes;

  modport source (
    output valid, now_time, has_enqueue_time, enqueue_time, size_known, packet_bytes,
    input  ready
  );
  modport sink (
    input  valid, now_time, has_enqueue_time, enqueue_time, size_known, packet_bytes,
    output ready
  );
endinterface

interface cdd_out_if;
  logic valid;
  logic ready;
  logic drop;
  logic dropping_now;

  modport source (output valid, drop, dropping_now, input ready);
  modport sink (input valid, drop, dropping_now, output ready);
endinterface

@@ rtl/cdd_ctrl.sv @@
// sequencer of the codel drop decider
module cdd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  cdd_pkg::status_t status,
  output cdd_pkg::cmd_t    cmd
);
  import cdd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_TSEL = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_MUL1 = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_ADD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]           state, state_next;
  logic [BIT_IDX_W-1:0] bitc, bitc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bitc  <= '0;
    end else begin
      state <= state_next;
      bitc  <= bitc_next;
    end
  end

  always_comb begin
    state_next = state;
    bitc_next  = bitc;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.to_spacing) begin
          state_next = ST_TSEL;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_TSEL: begin
        cmd.t_init = 1'b1;
        bitc_next  = BIT_IDX_W'(INV_W - 1);
        state_next = status.need_search ? ST_SRCH : ST_MUL1;
      end
      ST_SRCH: begin
        cmd.srch_step = 1'b1;
        cmd.srch_bit  = bitc;
        if (bitc == '0) begin
          state_next = ST_MUL1;
        end else begin
          bitc_next = bitc - 1'b1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/cdd_datapath.sv @@
// configuration, drop state, inverse square root search and spacing arithmetic
module cdd_datapath #(
  parameter int COUNT_BITS = cdd_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [cdd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [cdd_pkg::CFG_DATA_W-1:0]  wr_data,
  input  cdd_pkg::cmd_t                   cmd,
  output cdd_pkg::status_t                status,
  input  logic [cdd_pkg::TIME_W-1:0]      now_time,
  input  logic                            has_enqueue_time,
  input  logic [cdd_pkg::TIME_W-1:0]      enqueue_time,
  input  logic                            size_known,
  input  logic [cdd_pkg::BYTES_W-1:0]     packet_bytes,
  input  logic                            rsp_ready,
  output logic                            rsp_valid,
  output logic                            rsp_drop,
  output logic                            rsp_dropping_now
);
  import cdd_pkg::*;

  localparam int PROD_W  = SQ_W + COUNT_BITS;
  localparam int PROD1_W = IV_US_W + INV_W;

  logic [TIME_W-1:0]     now_r, enq_r;
  logic                  has_enq_r, size_known_r;
  logic [BYTES_W-1:0]    bytes_r;

  logic [IV_US_W-1:0]    iv_us;
  logic [IV_NS_W-1:0]    iv_ns;
  logic [TGT_MS_W-1:0]   tgt_ms;
  logic [TGT_NS_W-1:0]   tgt_ns;
  logic [BYTES_W-1:0]    max_bytes;
  logic [IV_MS_W-1:0]    eff_ms;

  logic                  dropping;
  logic [COUNT_BITS-1:0] count;
  logic [STAMP_W-1:0]    first_above, next_drop;

  logic [INV_W-1:0]      inv, cand;
  logic [SQ_W-1:0]       sq, cand_sq;
  logic [PROD_W-1:0]     prod;
  logic                  fits;
  logic [PROD1_W-1:0]    prod1;
  logic [SPACING_W-1:0]  spacing;

  logic                  res_drop, res_drop_next, dropping_next;

  logic [CMP_W-1:0]      now_w, enq_lim, fa_w, nd_w, fa_end, nd_end;
  logic                  stop, fa_unset, before_fa, in_cycle, recently, before_nd;
  logic                  eval_keep, enter, again;

  // configuration, derived time constants
  assign eff_ms = (wr_data == '0) ? INTERVAL_RESET : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv_us     <= IV_US_RESET;
      iv_ns     <= IV_NS_RESET;
      tgt_ms    <= TGT_MS_RESET;
      tgt_ns    <= TGT_NS_RESET;
      max_bytes <= MAX_BYTES_RESET;
    end else begin
      tgt_ns <= TGT_NS_W'(TGT_NS_W'(tgt_ms) * TGT_NS_W'(NS_PER_MS));
      if (wr_en) begin
        case (wr_index)
          CFG_INTERVAL: begin
            iv_us  <= IV_US_W'(IV_US_W'(eff_ms) * IV_US_W'(US_PER_MS));
            iv_ns  <= IV_NS_W'(IV_NS_W'(eff_ms) * IV_NS_W'(NS_PER_MS));
            tgt_ms <= TGT_MS_W'((20'(eff_ms) * 20'(TARGET_NUM)) >> TARGET_SHIFT);
          end
          CFG_MAX_BYTES: begin
            max_bytes <= wr_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // decision
  assign now_w     = CMP_W'(now_r);
  assign enq_lim   = CMP_W'(enq_r) + CMP_W'(tgt_ns);
  assign fa_w      = CMP_W'(first_above);
  assign nd_w      = CMP_W'(next_drop);
  assign fa_end    = fa_w + CMP_W'(iv_ns);
  assign nd_end    = nd_w + CMP_W'(iv_ns);

  assign stop      = !has_enq_r || (now_w < enq_lim) || (size_known_r && bytes_r <= max_bytes);
  assign fa_unset  = (first_above == '0);
  assign before_fa = now_w < fa_w;
  assign in_cycle  = (next_drop != '0) && (now_w < nd_end);
  assign recently  = in_cycle || (now_w >= fa_end);
  assign before_nd = now_w < nd_w;
  assign eval_keep = !stop && !fa_unset && !before_fa;
  assign enter     = eval_keep && !dropping && recently;
  assign again     = eval_keep && dropping && !before_nd;

  assign dropping_next = cmd.eval ? (eval_keep && (dropping || recently)) : dropping;
  assign res_drop_next = cmd.add ? 1'b1 : (cmd.eval ? 1'b0 : res_drop);

  // inverse square root, one bit per step
  assign cand    = inv | (INV_W'(1) << cmd.srch_bit);
  assign cand_sq = SQ_W'(sq + (SQ_W'(inv) << (32'(cmd.srch_bit) + 1))
                   + (SQ_W'(1) << (2 * 32'(cmd.srch_bit))));
  assign prod    = PROD_W'(cand_sq) * PROD_W'(count);
  assign fits    = prod <= PROD_W'(SQ_LIMIT);

  assign status.to_spacing  = enter || again;
  assign status.need_search = (count != '0) && (64'(count) < 64'(TABLE_LEN));
  assign status.out_free    = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r        <= now_time;
      has_enq_r    <= has_enqueue_time;
      enq_r        <= enqueue_time;
      size_known_r <= size_known;
      bytes_r      <= packet_bytes;
    end
    if (cmd.t_init) begin
      if (count == '0) begin
        inv <= T_ZERO;
      end else if (status.need_search) begin
        inv <= '0;
      end else begin
        inv <= T_TAIL;
      end
      sq <= '0;
    end else if (cmd.srch_step && fits) begin
      inv <= cand;
      sq  <= cand_sq;
    end
    if (cmd.mul1) begin
      prod1 <= PROD1_W'(iv_us) * PROD1_W'(inv);
    end
    if (cmd.mul2) begin
      spacing <= SPACING_W'(SPACING_W'(prod1[PROD1_W-1:T_SHIFT]) * SPACING_W'(NS_PER_US));
    end
    res_drop <= res_drop_next;
    if (cmd.out_load) begin
      rsp_drop         <= res_drop_next;
      rsp_dropping_now <= dropping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropping    <= 1'b0;
      count       <= '0;
      first_above <= '0;
      next_drop   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      dropping <= dropping_next;
      if (cmd.eval) begin
        if (stop) begin
          first_above <= '0;
        end else if (fa_unset) begin
          first_above <= STAMP_W'(now_w + CMP_W'(iv_ns));
        end
        if (enter) begin
          if (in_cycle && count > COUNT_BITS'(DEC_STEP)) begin
            count <= count - COUNT_BITS'(DEC_STEP);
          end else begin
            count <= COUNT_BITS'(1);
          end
          next_drop <= STAMP_W'(now_r);
        end else if (again && count != '1) begin
          count <= count + COUNT_BITS'(1);
        end
      end
      if (cmd.add) begin
        next_drop <= STAMP_W'(nd_w + CMP_W'(spacing));
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/codel_drop_decider_unit.sv @@
// top level of the codel drop decider
// One drop decision per dequeued packet. The block takes an item only while no
// other item is in work; a finished result sits in an output register, so the
// next item can enter while it waits. An item that schedules no drop passes
// through capture and evaluation only. A scheduled drop adds the spacing
// computation: the inverse square root is fixed when the drop count is zero or
// past the table range, and is otherwise found by an 8-step bit search through
// one 16 x COUNT_BITS multiplier. A write of the interval register takes effect
// for items accepted from the following cycle on.
module codel_drop_decider_unit #(
  parameter int COUNT_BITS = cdd_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  cdd_in_if.sink                          req,
  cdd_out_if.source                       rsp,
  input  logic                            wr_en,
  input  logic [cdd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [cdd_pkg::CFG_DATA_W-1:0]  wr_data
);
  import cdd_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    ready;

  cdd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .status    (status),
    .cmd       (cmd)
  );

  cdd_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .cmd              (cmd),
    .status           (status),
    .now_time         (req.now_time),
    .has_enqueue_time (req.has_enqueue_time),
    .enqueue_time     (req.enqueue_time),
    .size_known       (req.size_known),
    .packet_bytes     (req.packet_bytes),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .rsp_drop         (rsp.drop),
    .rsp_dropping_now (rsp.dropping_now)
  );

  assign req.ready = ready;

endmodule

@@ rtl/cdd_checker.sv @@
// port-level checks of the codel drop decider
module cdd_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic drop,
  input logic dropping_now
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item accepted while another is in work");

  // a drop only happens in the dropping state
  a_drop_state: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!drop || dropping_now))
    else $error("drop outside dropping state");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(drop) && $stable(dropping_now)))
    else $error("stalled result changed");

endmodule

bind codel_drop_decider_unit cdd_checker u_cdd_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .drop         (rsp.drop),
  .dropping_now (rsp.dropping_now)
);
